[hdl/servo_command_frame_builder_top_macros.svh]
// Assertion macros used by the frame builder checker
`ifndef SERVO_COMMAND_FRAME_BUILDER_TOP_MACROS_SVH
`define SERVO_COMMAND_FRAME_BUILDER_TOP_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define SCFB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame builder check failed: next-cycle property");

// Consequent must hold in the same cycle as the antecedent.
`define SCFB_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame builder check failed: same-cycle property");

`endif

[hdl/scfb_pkg.sv]
// Types and constants shared by the servo command frame builder
package scfb_pkg;

   typedef enum logic [1:0] {
      CMD_CONTROL  = 2'd0,
      CMD_POSITION = 2'd1,
      CMD_READ     = 2'd2,
      CMD_INVALID  = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      CSR_DEVICE_ADDRESS = 2'd0,
      CSR_CONTROL_CODE   = 2'd1,
      CSR_WRITE_CODE     = 2'd2,
      CSR_READ_CODE      = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BYTE,
      ST_SHIFT,
      ST_CRC_LO,
      ST_CRC_HI
   } state_type;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [7:0] QTY_HI     = 8'h00;
   localparam logic [7:0] QTY_LO     = 8'h02;
   localparam logic [7:0] BYTE_COUNT = 8'h04;

   localparam logic [3:0] LAST_IDX_POSITION = 4'd10;
   localparam logic [3:0] LAST_IDX_SHORT    = 4'd5;
   localparam logic [2:0] LAST_BIT          = 3'd7;

   typedef struct packed {
      logic [4:0] device_address;
      logic [7:0] control_code;
      logic [7:0] write_code;
      logic [7:0] read_code;
   } cfg_type;

   typedef struct packed {
      logic       init;
      logic       load;
      logic       shift;
      logic [7:0] data;
   } crc_ctrl_type;

   typedef struct packed {
      logic       load;
      logic [7:0] data;
      logic       last;
   } emit_type;

endpackage

[hdl/scfb_crc_unit.sv]
// Bit-serial CRC-16/MODBUS unit: fold in a byte, then one shift step per cycle
module scfb_crc_unit (
   input  logic                  clock,
   input  scfb_pkg::crc_ctrl_type ctrl,
   output logic [15:0]           crc
);
   import scfb_pkg::*;

   logic [15:0] crc_ff;
   logic [15:0] crc_in;

   always_comb begin
      crc_in = crc_ff;
      priority if (ctrl.init) begin
         crc_in = CRC_INIT;
      end else if (ctrl.load) begin
         crc_in = crc_ff ^ {8'h00, ctrl.data};
      end else if (ctrl.shift) begin
         // reflected polynomial: shift right, fold in when the low bit drops out
         crc_in = crc_ff[0] ? ((crc_ff >> 1) ^ CRC_POLY) : (crc_ff >> 1);
      end else begin
         crc_in = crc_ff;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
   end

   assign crc = crc_ff;

endmodule

[hdl/scfb_seq.sv]
// Frame sequencer: picks each frame byte and steps the shared CRC unit
module scfb_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_accept,
   input  scfb_pkg::command_type  req_command,
   input  logic [15:0]            req_register_address,
   input  logic [15:0]            req_register_value,
   input  logic [31:0]            req_position,
   input  scfb_pkg::cfg_type      cfg,
   input  logic                   slot_free,
   input  logic [15:0]            crc,
   output logic                   ready,
   output scfb_pkg::crc_ctrl_type crc_ctrl,
   output scfb_pkg::emit_type     emit
);
   import scfb_pkg::*;

   state_type   state_ff, state_in;
   logic [3:0]  idx_ff, idx_in;
   logic [2:0]  bit_ff, bit_in;
   command_type kind_ff;
   logic [15:0] reg_ff;
   logic [15:0] val_ff;
   logic [31:0] pos_ff;
   logic [3:0]  last_idx;
   logic [7:0]  frame_byte;
   logic [7:0]  func_code;

   assign last_idx = (kind_ff == CMD_POSITION) ? LAST_IDX_POSITION : LAST_IDX_SHORT;

   always_comb begin
      unique case (kind_ff)
         CMD_CONTROL:  func_code = cfg.control_code;
         CMD_POSITION: func_code = cfg.write_code;
         CMD_READ:     func_code = cfg.read_code;
         default:      func_code = cfg.read_code;
      endcase
   end

   always_comb begin
      frame_byte = 8'h00;
      unique case (idx_ff)
         4'd0: frame_byte = {3'b000, cfg.device_address};
         4'd1: frame_byte = func_code;
         4'd2: frame_byte = reg_ff[15:8];
         4'd3: frame_byte = reg_ff[7:0];
         4'd4: frame_byte = (kind_ff == CMD_POSITION) ? QTY_HI : val_ff[15:8];
         4'd5: frame_byte = (kind_ff == CMD_POSITION) ? QTY_LO : val_ff[7:0];
         4'd6: frame_byte = BYTE_COUNT;
         4'd7: frame_byte = pos_ff[31:24];
         4'd8: frame_byte = pos_ff[23:16];
         4'd9: frame_byte = pos_ff[15:8];
         4'd10: frame_byte = pos_ff[7:0];
         default: frame_byte = 8'h00;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_command != CMD_INVALID)) state_in = ST_BYTE;
         end
         ST_BYTE: begin
            if (slot_free) state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            if (bit_ff == LAST_BIT) state_in = (idx_ff == last_idx) ? ST_CRC_LO : ST_BYTE;
         end
         ST_CRC_LO: begin
            if (slot_free) state_in = ST_CRC_HI;
         end
         ST_CRC_HI: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // counters
   always_comb begin
      idx_in = idx_ff;
      bit_in = bit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = 4'd0;
            bit_in = 3'd0;
         end
         ST_BYTE: begin
            bit_in = 3'd0;
         end
         ST_SHIFT: begin
            bit_in = bit_ff + 3'd1;
            if (bit_ff == LAST_BIT) idx_in = idx_ff + 4'd1;
         end
         ST_CRC_LO, ST_CRC_HI: begin
            idx_in = idx_ff;
         end
         default: idx_in = 4'd0;
      endcase
   end

   // outputs
   always_comb begin
      ready         = (state_ff == ST_IDLE);
      crc_ctrl.init = (state_ff == ST_IDLE) && req_accept;
      crc_ctrl.load = (state_ff == ST_BYTE) && slot_free;
      crc_ctrl.shift = (state_ff == ST_SHIFT);
      crc_ctrl.data = frame_byte;
      emit.load     = 1'b0;
      emit.data     = frame_byte;
      emit.last     = 1'b0;
      unique case (state_ff)
         ST_BYTE: begin
            emit.load = slot_free;
         end
         ST_CRC_LO: begin
            emit.load = slot_free;
            emit.data = crc[7:0];
         end
         ST_CRC_HI: begin
            emit.load = slot_free;
            emit.data = crc[15:8];
            emit.last = 1'b1;
         end
         ST_IDLE, ST_SHIFT: begin
            emit.load = 1'b0;
         end
         default: emit.load = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= 4'd0;
         bit_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         bit_ff   <= bit_in;
      end
   end

   // hold the request fields for the whole frame
   always_ff @(posedge clock) begin
      if (ready && req_accept) begin
         kind_ff <= req_command;
         reg_ff  <= req_register_address;
         val_ff  <= req_register_value;
         pos_ff  <= req_position;
      end
   end

endmodule

[hdl/servo_command_frame_builder_top.sv]
// Servo command frame builder: request in, Modbus-RTU style byte stream out
//
// Each request word on req_ becomes one frame on rsp_, one byte per word, most
// significant byte first, closed by the CRC-16/MODBUS low then high byte; the high
// byte carries rsp_tlast. Control and read requests give 8 bytes, position writes
// give 13, and the invalid command is dropped with no output. The CRC is kept by a
// single bit-serial unit, so every data byte is loaded into it and then taken through
// eight shift steps, while the two CRC bytes go from it straight to the output
// register. req_tready is high only between frames; the last byte may still wait in
// the output register while the next request is taken.
module servo_command_frame_builder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // register_address[15:0], register_value[31:16],
                                   // position[63:32]
   input  logic [1:0]  req_tuser,  // command[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // tx_byte[7:0]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [7:0]  csr_wdata
);
   import scfb_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   rsp_data_ff;
   logic         rsp_last_ff;
   logic         slot_free;
   logic         req_accept;
   logic [15:0]  crc;
   crc_ctrl_type crc_ctrl;
   emit_type     emit;

   assign req_accept = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_DEVICE_ADDRESS: cfg_in.device_address = csr_wdata[4:0];
            CSR_CONTROL_CODE:   cfg_in.control_code   = csr_wdata;
            CSR_WRITE_CODE:     cfg_in.write_code     = csr_wdata;
            CSR_READ_CODE:      cfg_in.read_code      = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address <= 5'd1;
         cfg_ff.control_code   <= 8'd6;
         cfg_ff.write_code     <= 8'd16;
         cfg_ff.read_code      <= 8'd3;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   scfb_seq u_seq (
      .clock                (clock),
      .reset                (reset),
      .req_accept           (req_accept),
      .req_command          (command_type'(req_tuser)),
      .req_register_address (req_tdata[15:0]),
      .req_register_value   (req_tdata[31:16]),
      .req_position         (req_tdata[63:32]),
      .cfg                  (cfg_ff),
      .slot_free            (slot_free),
      .crc                  (crc),
      .ready                (req_tready),
      .crc_ctrl             (crc_ctrl),
      .emit                 (emit)
   );

   scfb_crc_unit u_crc (
      .clock (clock),
      .ctrl  (crc_ctrl),
      .crc   (crc)
   );

   // output register: load a new word when free, drop valid once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.load) begin
         rsp_data_ff <= emit.data;
         rsp_last_ff <= emit.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[hdl/scfb_checker.sv]
// Port-level checks for the servo command frame builder, bound to the top level
`include "servo_command_frame_builder_top_macros.svh"

module scfb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [1:0] req_tuser,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);
   import scfb_pkg::*;

   // a stalled word stays offered and unchanged
   `SCFB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `SCFB_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tlast))

   // a real request closes the input until its frame is built
   `SCFB_ASSERT_NEXT(a_busy_after_cmd, clock, reset, req_tvalid && req_tready && (req_tuser != CMD_INVALID), !req_tready)

   // an invalid command is dropped and leaves the block open
   `SCFB_ASSERT_NEXT(a_drop_invalid, clock, reset, req_tvalid && req_tready && (req_tuser == CMD_INVALID), req_tready && !(rsp_tvalid && !$past(rsp_tvalid)))

   // no new word appears while the block waits for a request
   `SCFB_ASSERT_SAME(a_idle_quiet, clock, reset, req_tready && $past(req_tready) && !$past(rsp_tvalid), !rsp_tvalid)

endmodule

bind servo_command_frame_builder_top scfb_checker u_scfb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
